// ===== rtl/sdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrc_pkg - shared types and constants
// Word types of both channels, register indexes, sequencer states and
// parameter defaults of the dark/reference correction block.
// ----------------------------------------------------------------------------
package sdrc_pkg;

   localparam int PIXELS_DEFAULT        = 4096;
   localparam int COUNT_BITS_DEFAULT    = 16;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int RAW_W   = 16;
   localparam int IDX_W   = 12;
   localparam int OUT_W   = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SUBTRACT_DARK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE     = 1'd1;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [RAW_W-1:0] raw_count;
      logic [IDX_W-1:0] pixel_index;
      logic             capture_dark;
      logic             capture_reference;
      logic             last_pixel;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] corrected_value;
      logic                    is_ratio;
      logic                    divide_fault;
      logic                    frame_end;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LOAD,
      ST_DIVIDE
   } sdrc_state_type;

endpackage

// ===== rtl/spectrum_dark_reference_correction.sv =====
// ----------------------------------------------------------------------------
// spectrum_dark_reference_correction - dark subtraction and normalisation
// Per-pixel dark frame subtraction and division by a captured reference
// frame, result in signed fixed point with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel: one pixel word (raw count, index, capture commands, last
//   pixel flag); taken when req_valid is high and req_stall is low.
//   rsp_ channel: one result word per pixel, in order; held while rsp_stall
//   is high. csr_ port: write enable, index, data; write only while idle.
//   Each word passes the lookup, load and divide states before rsp_valid;
//   the bit-serial divider produces one quotient bit a cycle. Unnormalised
//   pixels go through the same divider with a divisor of one. A finished
//   word sits in the output register, so the next pixel is taken while the
//   receiver stalls; a second result waits in the divider until the output
//   register frees. A new pixel is taken only in idle, after the last result
//   has left the divider.
//   Reset: synchronous, active high. The dark store is then cleared entry by
//   entry, one entry a cycle, with req_stall high. Reference entries are
//   undefined until captured. Registers and the normalisation arm bit reset
//   to zero.
// ----------------------------------------------------------------------------
module spectrum_dark_reference_correction #(
   parameter int PIXELS        = sdrc_pkg::PIXELS_DEFAULT,
   parameter int COUNT_BITS    = sdrc_pkg::COUNT_BITS_DEFAULT,
   parameter int FRACTION_BITS = sdrc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sdrc_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sdrc_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_write_enable,
   input  logic [sdrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sdrc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import sdrc_pkg::*;

   localparam int AW   = $clog2(PIXELS);
   localparam int CB   = COUNT_BITS;
   localparam int NW   = COUNT_BITS + FRACTION_BITS;
   localparam int VW   = (NW + 1 > OUT_W) ? NW + 1 : OUT_W;
   localparam int CMPW = ((AW > IDX_W) ? AW : IDX_W) + 1;
   localparam logic signed [VW-1:0] VMAX = VW'(OUT_MAX);
   localparam logic signed [VW-1:0] VMIN = VW'(OUT_MIN);

   // sequencer and control state
   sdrc_state_type state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic           sub_en_ff, sub_en_in;
   logic           norm_en_ff, norm_en_in;
   logic           armed_ff, armed_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload
   req_word_type   item_ff, item_in;
   logic           ratio_ff, ratio_in;
   logic           fault_ff, fault_in;
   logic           neg_ff, neg_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   // stores and divider
   logic           dark_we;
   logic [AW-1:0]  dark_waddr;
   logic [CB-1:0]  dark_wdata;
   logic [CB-1:0]  dark_rdata;
   logic           ref_we;
   logic [CB:0]    ref_rdata;
   logic           div_start;
   logic           div_done;
   logic [NW-1:0]  div_q;
   logic [CB-1:0]  div_dividend;
   logic [CB-1:0]  div_divisor;

   // datapath
   logic            req_take;
   logic            rsp_load;
   logic [CMPW-1:0] idx_ext;
   logic            in_range;
   logic [AW-1:0]   item_addr;
   logic [CB-1:0]   raw;
   logic [CB-1:0]   dark_eff;
   logic [CB:0]     corr;
   logic [CB:0]     corr_abs;
   logic [CB:0]     ref_eff;
   logic [CB:0]     ref_abs;
   logic            armed_eff;
   logic signed [VW-1:0] mag_s;
   logic signed [VW-1:0] val_s;
   logic signed [VW-1:0] clamp_s;

   assign req_take = req_valid && !req_stall;

   // ---- item decode ----
   always_comb begin
      idx_ext   = CMPW'(item_ff.pixel_index);
      in_range  = (idx_ext < CMPW'(PIXELS));
      item_addr = AW'(idx_ext);
      raw       = CB'(item_ff.raw_count);
      // a dark capture uses the fresh raw count, so subtraction yields zero
      if (!in_range) begin
         dark_eff = '0;
      end else if (item_ff.capture_dark) begin
         dark_eff = raw;
      end else begin
         dark_eff = dark_rdata;
      end
      corr      = {1'b0, raw} - (sub_en_ff ? {1'b0, dark_eff} : '0);
      corr_abs  = corr[CB] ? (~corr + (CB+1)'(1)) : corr;
      // a reference capture divides the pixel by itself; a stray index reads zero
      if (!in_range) begin
         ref_eff = '0;
      end else if (item_ff.capture_reference) begin
         ref_eff = corr;
      end else begin
         ref_eff = ref_rdata;
      end
      ref_abs      = ref_eff[CB] ? (~ref_eff + (CB+1)'(1)) : ref_eff;
      armed_eff    = armed_ff || item_ff.capture_reference;
      div_dividend = corr_abs[CB-1:0];
      div_divisor  = armed_eff ? ref_abs[CB-1:0] : CB'(1);
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(PIXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // ---- sequencer outputs ----
   always_comb begin
      req_stall  = 1'b1;
      dark_we    = 1'b0;
      dark_waddr = item_addr;
      dark_wdata = raw;
      ref_we     = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            dark_we    = 1'b1;
            dark_waddr = clr_cnt_ff;
            dark_wdata = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_LOOKUP: begin
         end
         ST_LOAD: begin
            dark_we   = item_ff.capture_dark && in_range;
            ref_we    = item_ff.capture_reference && in_range;
            div_start = 1'b1;
         end
         ST_DIVIDE: begin
            rsp_load = div_done && (!rsp_valid_ff || !rsp_stall);
         end
         default: begin
         end
      endcase
   end

   // ---- register next values ----
   always_comb begin
      clr_cnt_in   = (state_ff == ST_CLEAR) ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      sub_en_in    = sub_en_ff;
      norm_en_in   = norm_en_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SUBTRACT_DARK: sub_en_in  = csr_write_data[0];
            CSR_NORMALIZE:     norm_en_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
      item_in  = req_take ? req_word : item_ff;
      armed_in = armed_ff;
      ratio_in = ratio_ff;
      fault_in = fault_ff;
      neg_in   = neg_ff;
      if (state_ff == ST_LOAD) begin
         // arm on capture, then drop at frame end unless normalisation stays on
         armed_in = armed_eff && !(item_ff.last_pixel && !norm_en_ff);
         ratio_in = armed_eff;
         fault_in = armed_eff && (ref_eff == '0);
         neg_in   = corr[CB] ^ (armed_eff && ref_eff[CB]);
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // ---- result formation: sign, saturate, force zero on fault ----
   always_comb begin
      mag_s   = $signed(VW'(div_q));
      val_s   = neg_ff ? -mag_s : mag_s;
      if (val_s > VMAX) begin
         clamp_s = VMAX;
      end else if (val_s < VMIN) begin
         clamp_s = VMIN;
      end else begin
         clamp_s = val_s;
      end
      rsp_word_in = rsp_word_ff;
      if (rsp_load) begin
         rsp_word_in.corrected_value = fault_ff ? '0 : OUT_W'(clamp_s);
         rsp_word_in.is_ratio        = ratio_ff;
         rsp_word_in.divide_fault    = fault_ff;
         rsp_word_in.frame_end       = item_ff.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         sub_en_ff    <= 1'b0;
         norm_en_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         sub_en_ff    <= sub_en_in;
         norm_en_ff   <= norm_en_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      ratio_ff    <= ratio_in;
      fault_ff    <= fault_in;
      neg_ff      <= neg_in;
      rsp_word_ff <= rsp_word_in;
   end

   // ---- stores: read in the lookup cycle, written in the load cycle ----
   sdrc_ram #(
      .WIDTH (CB),
      .DEPTH (PIXELS)
   ) u_dark_ram (
      .clock         (clock),
      .write_enable  (dark_we),
      .write_address (dark_waddr),
      .write_data    (dark_wdata),
      .read_address  (item_addr),
      .read_data     (dark_rdata)
   );

   sdrc_ram #(
      .WIDTH (CB + 1),
      .DEPTH (PIXELS)
   ) u_ref_ram (
      .clock         (clock),
      .write_enable  (ref_we),
      .write_address (item_addr),
      .write_data    (corr),
      .read_address  (item_addr),
      .read_data     (ref_rdata)
   );

   sdrc_serial_div #(
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend_mag (div_dividend),
      .divisor_mag  (div_divisor),
      .done         (div_done),
      .quotient     (div_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---- assertions ----
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("pixel word accepted during dark store clear");

   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_LOOKUP))
      else $error("accepted word did not start a lookup");

   a_load_fills_output: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished result not placed in output register");

   a_fault_is_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_word_ff.divide_fault || rsp_word_ff.is_ratio))
      else $error("divide fault flagged on unnormalised word");

endmodule

// ===== rtl/sdrc_ram.sv =====
// ----------------------------------------------------------------------------
// sdrc_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sdrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/sdrc_serial_div.sv =====
// ----------------------------------------------------------------------------
// sdrc_serial_div - bit-serial restoring divider
// Divides {dividend, FRACTION_BITS zeros} by divisor, one quotient bit per
// cycle, magnitudes only.
// ----------------------------------------------------------------------------
module sdrc_serial_div #(
   parameter int COUNT_BITS    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [COUNT_BITS-1:0]               dividend_mag,
   input  logic [COUNT_BITS-1:0]               divisor_mag,
   output logic                                done,
   output logic [COUNT_BITS+FRACTION_BITS-1:0] quotient
);

   localparam int NW = COUNT_BITS + FRACTION_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [NW-1:0]         dq_ff, dq_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  qbit;

   always_comb begin
      trial   = {rem_ff, dq_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      qbit    = (trial >= {1'b0, den_ff});
      cnt_in  = cnt_ff;
      done_in = done_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in  = CW'(NW);
         done_in = 1'b0;
         dq_in   = {dividend_mag, {FRACTION_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = divisor_mag;
      end else if (cnt_ff != '0) begin
         // shift one dividend bit in, one quotient bit out
         cnt_in = cnt_ff - CW'(1);
         dq_in  = {dq_ff[NW-2:0], qbit};
         rem_in = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         if (cnt_ff == CW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule
